>>> hdl/kcs_pkg.sv
// Shared definitions for the keyframe camera sampler.
// Holds default sizes, request and register codes, and the controller/datapath interface types.
// No dependencies.
package kcs_pkg;

  // Default table sizes
  localparam int DEF_MAX_CAMERAS        = 64;
  localparam int DEF_MAX_KEYS           = 256;
  localparam int DEF_MAX_TRACKS         = 64;
  localparam int DEF_MAX_KEYS_PER_TRACK = 32;
  localparam int DEF_MAX_EDIT_TRACKS    = 16;

  // Request codes carried by req_type
  localparam logic [2:0] REQ_CAMERA    = 3'd0;
  localparam logic [2:0] REQ_KEY       = 3'd1;
  localparam logic [2:0] REQ_TRACK     = 3'd2;
  localparam logic [2:0] REQ_TRACK_KEY = 3'd3;
  localparam logic [2:0] REQ_EDIT      = 3'd4;
  localparam logic [2:0] REQ_SAMPLE    = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_DURATION     = 3'd0;
  localparam logic [2:0] CFG_CAMERA_COUNT = 3'd1;
  localparam logic [2:0] CFG_KEY_COUNT    = 3'd2;
  localparam logic [2:0] CFG_TRACK_COUNT  = 3'd3;
  localparam logic [2:0] CFG_EDIT_COUNT   = 3'd4;

  localparam int CFG_DATA_W  = 16;
  localparam int FIELD_COUNT = 8;
  localparam logic [2:0] LAST_FIELD = 3'd7;

  // Datapath commands issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_EDIT_RD,
    OP_NEXT_TRACK,
    OP_TRK_RD,
    OP_TRK_NEXT,
    OP_TRK_TAKE,
    OP_KL_RD,
    OP_KEY_RD,
    OP_KEY_NEXT,
    OP_KEY_TAKE,
    OP_PAIR_START,
    OP_PAIR_RD,
    OP_PAIR_NEXT,
    OP_PAIR_LAST,
    OP_PAIR_HIT,
    OP_CAM_RD,
    OP_CAM_STEP,
    OP_FLD_START,
    OP_FLD_RD0,
    OP_FLD_RD1,
    OP_BLEND_GO,
    OP_FLD_STORE,
    OP_OUT_HIT,
    OP_OUT_MISS
  } kcs_op_t;

  // Datapath status returned to the controller
  typedef struct packed {
    logic late;
    logic edit_end;
    logic trk_end;
    logic trk_match;
    logic len_zero;
    logic kl_end;
    logic key_end;
    logic key_match;
    logic pair_hit;
    logic pair_last;
    logic cam_end;
    logic cam_found;
    logic fld_last;
    logic blend_done;
    logic out_free;
  } kcs_stat_t;

endpackage

>>> hdl/kcs_blend.sv
// Iterative interpolation unit: a + (b-a)*u/span, truncated toward zero, saturated.
// One quotient digit per cycle, 33 steps; no multiplier and no divider.
// No dependencies.
module kcs_blend (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic        [31:0] u,
  input  logic        [31:0] span,
  output logic               done,
  output logic signed [31:0] result
);

  logic               busy;
  logic        [5:0]  cnt;
  logic        [32:0] m;
  logic        [31:0] r;
  logic        [32:0] q;
  logic        [31:0] u_r;
  logic        [31:0] sp;
  logic               neg;
  logic signed [31:0] a_r;

  logic signed [32:0] diff;
  logic        [33:0] x;
  logic        [33:0] x1;
  logic        [33:0] x2;
  logic               ge1;
  logic               ge2;
  logic        [31:0] r_next;
  logic        [32:0] q_next;
  logic signed [33:0] q_s;
  logic signed [33:0] sum;

  // Signed difference of the field values
  assign diff = $signed({b[31], b}) - $signed({a[31], a});

  // One step of m*u/span, remainder kept below span, digit 0..2
  assign x      = {1'b0, r, 1'b0} + (m[32] ? {2'b00, u_r} : 34'd0);
  assign x1     = x - {2'b00, sp};
  assign x2     = x - {1'b0, sp, 1'b0};
  assign ge2    = x >= {1'b0, sp, 1'b0};
  assign ge1    = x >= {2'b00, sp};
  assign r_next = ge2 ? x2[31:0] : (ge1 ? x1[31:0] : x[31:0]);
  assign q_next = {q[31:0], 1'b0} + (ge2 ? 33'd2 : (ge1 ? 33'd1 : 33'd0));

  // Apply sign and saturate
  assign q_s = $signed({1'b0, q});
  assign sum = $signed({{2{a_r[31]}}, a_r}) + (neg ? -q_s : q_s);

  always_comb begin
    if (sp == 32'd0) begin
      result = a_r;
    end else if (sum > 34'sh0_7FFF_FFFF) begin
      result = 32'sh7FFF_FFFF;
    end else if (sum < -34'sh0_8000_0000) begin
      result = -32'sh8000_0000;
    end else begin
      result = sum[31:0];
    end
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd33;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      m   <= diff[32] ? 33'(-diff) : 33'(diff);
      neg <= diff[32];
      a_r <= a;
      u_r <= u;
      sp  <= span;
      r   <= '0;
      q   <= '0;
    end else if (busy) begin
      m <= {m[31:0], 1'b0};
      r <= r_next;
      q <= q_next;
    end
  end

endmodule

>>> hdl/kcs_dp.sv
// Datapath of the keyframe camera sampler: tables, scan counters, blend unit and result register.
// Depends on kcs_pkg and kcs_blend.
module kcs_dp #(
  parameter int MAX_CAMERAS        = kcs_pkg::DEF_MAX_CAMERAS,
  parameter int MAX_KEYS           = kcs_pkg::DEF_MAX_KEYS,
  parameter int MAX_TRACKS         = kcs_pkg::DEF_MAX_TRACKS,
  parameter int MAX_KEYS_PER_TRACK = kcs_pkg::DEF_MAX_KEYS_PER_TRACK,
  parameter int MAX_EDIT_TRACKS    = kcs_pkg::DEF_MAX_EDIT_TRACKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  kcs_pkg::kcs_op_t                op,
  output kcs_pkg::kcs_stat_t              stat,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [kcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [2:0]                      req_type,
  input  logic [7:0]                      slot,
  input  logic [5:0]                      position,
  input  logic [2:0]                      field_sel,
  input  logic [31:0]                     id_a,
  input  logic [31:0]                     id_b,
  input  logic signed [31:0]              value,
  input  logic [31:0]                     sample_time,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            found,
  output logic signed [31:0]              eye_x,
  output logic signed [31:0]              eye_y,
  output logic signed [31:0]              eye_z,
  output logic signed [31:0]              look_x,
  output logic signed [31:0]              look_y,
  output logic signed [31:0]              look_z,
  output logic signed [31:0]              roll_out,
  output logic signed [31:0]              fov_out,
  output logic [3:0]                      track_pos,
  output logic [31:0]                     camera_id_out
);
  import kcs_pkg::*;

  localparam int CAW = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
  localparam int CW1 = $clog2(MAX_CAMERAS + 1);
  localparam int KAW = $clog2(MAX_KEYS);
  localparam int KW1 = $clog2(MAX_KEYS + 1);
  localparam int TAW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int TW1 = $clog2(MAX_TRACKS + 1);
  localparam int PAW = $clog2(MAX_KEYS_PER_TRACK);
  localparam int PW1 = $clog2(MAX_KEYS_PER_TRACK + 1);
  localparam int EAW = (MAX_EDIT_TRACKS > 1) ? $clog2(MAX_EDIT_TRACKS) : 1;
  localparam int EW1 = $clog2(MAX_EDIT_TRACKS + 1);
  localparam int TKW = $clog2(MAX_TRACKS * MAX_KEYS_PER_TRACK);
  localparam int FAW = CAW + 3;
  localparam int BW  = 33 + $clog2(MAX_EDIT_TRACKS);

  // Configuration registers
  logic [15:0] dur;
  logic [6:0]  cam_cnt;
  logic [8:0]  key_cnt;
  logic [6:0]  trk_cnt;
  logic [4:0]  edit_cnt;

  // Tables
  logic [31:0] cam_id_mem  [MAX_CAMERAS];
  logic [31:0] cam_fld_mem [MAX_CAMERAS * FIELD_COUNT];
  logic [95:0] key_mem     [MAX_KEYS];
  logic [37:0] trk_mem     [MAX_TRACKS];
  logic [31:0] tk_mem      [MAX_TRACKS * MAX_KEYS_PER_TRACK];
  logic [31:0] edit_mem    [MAX_EDIT_TRACKS];
  logic [63:0] ks_mem      [MAX_KEYS_PER_TRACK];

  logic [31:0] cam_id_q;
  logic [31:0] cam_fld_q;
  logic [95:0] key_q;
  logic [37:0] trk_q;
  logic [31:0] tk_q;
  logic [31:0] edit_q;
  logic [63:0] ks_q;

  // Walk registers
  logic [31:0]          t;
  logic signed [BW-1:0] base;
  logic [EW1-1:0]       ti;
  logic [TW1-1:0]       j;
  logic [PW1-1:0]       n;
  logic [PW1-1:0]       p;
  logic [KW1-1:0]       i;
  logic [31:0]          prev_cam;
  logic signed [31:0]   prev_frame;
  logic signed [BW:0]   prev_sum;
  logic [31:0]          cid0;
  logic [31:0]          cid1;
  logic [31:0]          u_r;
  logic [31:0]          span_r;
  logic [3:0]           pos;
  logic [CW1-1:0]       c;
  logic [CAW-1:0]       c0;
  logic [CAW-1:0]       c1;
  logic                 h0;
  logic                 h1;
  logic [2:0]           f;
  logic signed [31:0]   a_f;
  logic signed [31:0]   res [FIELD_COUNT];

  // Write strobes and addresses
  logic           load;
  logic           cam_we;
  logic           key_we;
  logic           trk_we;
  logic           tk_we;
  logic           edit_we;
  logic [CAW-1:0] cam_wa;
  logic [TKW-1:0] tk_wa;
  logic [TKW-1:0] tk_ra;
  logic [FAW-1:0] fld_ra;

  // Pair test terms
  logic signed [31:0] cur_frame;
  logic [31:0]        cur_cam;
  logic signed [BW:0] cur_sum;
  logic signed [BW:0] t_ext;
  logic signed [BW:0] u_wide;
  logic signed [32:0] span_wide;

  logic               blend_done;
  logic signed [31:0] blend_res;

  // Decode load beats
  assign load    = (op == OP_LOAD);
  assign cam_we  = load && (req_type == REQ_CAMERA) && (32'(slot) < MAX_CAMERAS);
  assign key_we  = load && (req_type == REQ_KEY) && (32'(slot) < MAX_KEYS);
  assign trk_we  = load && (req_type == REQ_TRACK) && (32'(slot) < MAX_TRACKS);
  assign tk_we   = load && (req_type == REQ_TRACK_KEY) && (32'(slot) < MAX_TRACKS)
                   && (32'(position) < MAX_KEYS_PER_TRACK);
  assign edit_we = load && (req_type == REQ_EDIT) && (32'(position) < MAX_EDIT_TRACKS);
  assign cam_wa  = CAW'(slot);
  assign tk_wa   = TKW'(32'(slot) * MAX_KEYS_PER_TRACK + 32'(position));
  assign tk_ra   = TKW'(32'(j) * MAX_KEYS_PER_TRACK + 32'(p));
  assign fld_ra  = (op == OP_FLD_RD1) ? {c1, f} : {c0, f};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dur      <= '0;
      cam_cnt  <= '0;
      key_cnt  <= '0;
      trk_cnt  <= '0;
      edit_cnt <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DURATION:     dur      <= cfg_data;
        CFG_CAMERA_COUNT: cam_cnt  <= cfg_data[6:0];
        CFG_KEY_COUNT:    key_cnt  <= cfg_data[8:0];
        CFG_TRACK_COUNT:  trk_cnt  <= cfg_data[6:0];
        CFG_EDIT_COUNT:   edit_cnt <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Camera id table
  always_ff @(posedge clk) begin
    if (cam_we) begin
      cam_id_mem[cam_wa] <= id_a;
    end
    if (op == OP_CAM_RD) begin
      cam_id_q <= cam_id_mem[c[CAW-1:0]];
    end
  end

  // Camera field table
  always_ff @(posedge clk) begin
    if (cam_we) begin
      cam_fld_mem[{cam_wa, field_sel}] <= value;
    end
    if (op == OP_FLD_RD0 || op == OP_FLD_RD1) begin
      cam_fld_q <= cam_fld_mem[fld_ra];
    end
  end

  // Key table: id, camera id, frame
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[KAW'(slot)] <= {id_a, id_b, value};
    end
    if (op == OP_KEY_RD) begin
      key_q <= key_mem[i[KAW-1:0]];
    end
  end

  // Track table: id, key count
  always_ff @(posedge clk) begin
    if (trk_we) begin
      trk_mem[TAW'(slot)] <= {id_a, position};
    end
    if (op == OP_TRK_RD) begin
      trk_q <= trk_mem[j[TAW-1:0]];
    end
  end

  // Track key lists
  always_ff @(posedge clk) begin
    if (tk_we) begin
      tk_mem[tk_wa] <= id_a;
    end
    if (op == OP_KL_RD) begin
      tk_q <= tk_mem[tk_ra];
    end
  end

  // Editing track list
  always_ff @(posedge clk) begin
    if (edit_we) begin
      edit_mem[EAW'(position)] <= id_a;
    end
    if (op == OP_EDIT_RD) begin
      edit_q <= edit_mem[ti[EAW-1:0]];
    end
  end

  // Resolved keys of the current track: camera id, frame
  always_ff @(posedge clk) begin
    if (op == OP_KEY_TAKE) begin
      ks_mem[p[PAW-1:0]] <= key_q[63:0];
    end
    if (op == OP_PAIR_RD) begin
      ks_q <= ks_mem[p[PAW-1:0]];
    end
  end

  // Pair window test against the running base
  assign cur_frame = $signed(ks_q[31:0]);
  assign cur_cam   = ks_q[63:32];
  assign t_ext     = $signed((BW + 1)'(t));
  assign cur_sum   = (BW + 1)'(cur_frame) + (BW + 1)'(base);
  assign u_wide    = t_ext - prev_sum;
  assign span_wide = $signed({cur_frame[31], cur_frame}) - $signed({prev_frame[31], prev_frame});

  // Status to the controller
  always_comb begin
    stat.late       = t >= {dur, 16'h0000};
    stat.edit_end   = (32'(ti) >= 32'(edit_cnt)) || (32'(ti) >= MAX_EDIT_TRACKS);
    stat.trk_end    = (32'(j) >= 32'(trk_cnt)) || (32'(j) >= MAX_TRACKS);
    stat.trk_match  = trk_q[37:6] == edit_q;
    stat.len_zero   = trk_q[5:0] == 6'd0;
    stat.kl_end     = p >= n;
    stat.key_end    = (32'(i) >= 32'(key_cnt)) || (32'(i) >= MAX_KEYS);
    stat.key_match  = key_q[95:64] == tk_q;
    stat.pair_hit   = (p != '0) && (prev_sum <= t_ext) && (t_ext < cur_sum);
    stat.pair_last  = (32'(p) + 32'd1) >= 32'(n);
    stat.cam_end    = (32'(c) >= 32'(cam_cnt)) || (32'(c) >= MAX_CAMERAS);
    stat.cam_found  = h0 && h1;
    stat.fld_last   = f == LAST_FIELD;
    stat.blend_done = blend_done;
    stat.out_free   = !out_valid || out_ready;
  end

  // Walk registers, advanced by command
  always_ff @(posedge clk) begin
    case (op)
      OP_START: begin
        t    <= sample_time;
        base <= '0;
        ti   <= '0;
      end
      OP_EDIT_RD:    j  <= '0;
      OP_NEXT_TRACK: ti <= ti + 1'b1;
      OP_TRK_NEXT:   j  <= j + 1'b1;
      OP_TRK_TAKE: begin
        n <= (32'(trk_q[5:0]) > MAX_KEYS_PER_TRACK) ? PW1'(MAX_KEYS_PER_TRACK)
                                                     : PW1'(trk_q[5:0]);
        p <= '0;
      end
      OP_KL_RD:      i <= '0;
      OP_KEY_NEXT:   i <= i + 1'b1;
      OP_KEY_TAKE:   p <= p + 1'b1;
      OP_PAIR_START: p <= '0;
      OP_PAIR_NEXT: begin
        prev_cam   <= cur_cam;
        prev_frame <= cur_frame;
        prev_sum   <= cur_sum;
        p          <= p + 1'b1;
      end
      OP_PAIR_LAST: begin
        base <= base + BW'(cur_frame);
        ti   <= ti + 1'b1;
      end
      OP_PAIR_HIT: begin
        cid0   <= prev_cam;
        cid1   <= cur_cam;
        u_r    <= u_wide[31:0];
        span_r <= span_wide[31:0];
        pos    <= 4'(ti);
        c      <= '0;
        h0     <= 1'b0;
        h1     <= 1'b0;
      end
      OP_CAM_STEP: begin
        // Last match wins
        if (cam_id_q == cid0) begin
          c0 <= c[CAW-1:0];
          h0 <= 1'b1;
        end
        if (cam_id_q == cid1) begin
          c1 <= c[CAW-1:0];
          h1 <= 1'b1;
        end
        c <= c + 1'b1;
      end
      OP_FLD_START: f   <= '0;
      OP_FLD_RD1:   a_f <= $signed(cam_fld_q);
      OP_FLD_STORE: begin
        res[f] <= blend_res;
        f      <= f + 3'd1;
      end
      default: ;
    endcase
  end

  kcs_blend u_blend (
    .clk    (clk),
    .rst    (rst),
    .start  (op == OP_BLEND_GO),
    .a      (a_f),
    .b      ($signed(cam_fld_q)),
    .u      (u_r),
    .span   (span_r),
    .done   (blend_done),
    .result (blend_res)
  );

  // Result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_OUT_HIT || op == OP_OUT_MISS) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT_HIT) begin
      found         <= 1'b1;
      eye_x         <= res[0];
      eye_y         <= res[1];
      eye_z         <= res[2];
      look_x        <= res[3];
      look_y        <= res[4];
      look_z        <= res[5];
      roll_out      <= res[6];
      fov_out       <= res[7];
      track_pos     <= pos;
      camera_id_out <= cid0;
    end else if (op == OP_OUT_MISS) begin
      found         <= 1'b0;
      eye_x         <= '0;
      eye_y         <= '0;
      eye_z         <= '0;
      look_x        <= '0;
      look_y        <= '0;
      look_z        <= '0;
      roll_out      <= '0;
      fov_out       <= '0;
      track_pos     <= '0;
      camera_id_out <= '0;
    end
  end

  // A finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (op == OP_OUT_HIT || op == OP_OUT_MISS) |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // A matched pair always spans a positive frame distance
  a_span_pos: assert property (@(posedge clk) disable iff (rst)
    (op == OP_PAIR_HIT) |-> (cur_frame > prev_frame))
    else $error("matched pair with empty span");

  // Resolved keys stay within the track's key count
  a_take_range: assert property (@(posedge clk) disable iff (rst)
    (op == OP_KEY_TAKE) |-> (p < n))
    else $error("key resolved beyond track length");

endmodule

>>> hdl/kcs_ctrl.sv
// Controller of the keyframe camera sampler: issues load beats and sequences the table walk of one sample.
// Depends on kcs_pkg.
module kcs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [2:0]         req_type,
  input  kcs_pkg::kcs_stat_t stat,
  output kcs_pkg::kcs_op_t   op,
  output logic               in_ready
);
  import kcs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EDIT,
    ST_TRK,
    ST_TRK_CMP,
    ST_KL,
    ST_KEY,
    ST_KEY_CMP,
    ST_PAIR,
    ST_PAIR_CMP,
    ST_CAM,
    ST_CAM_CMP,
    ST_FLD,
    ST_FLD_A,
    ST_FLD_B,
    ST_BLEND,
    ST_HIT,
    ST_MISS
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and command
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_SAMPLE) begin
            op         = OP_START;
            state_next = ST_CHECK;
          end else begin
            op = OP_LOAD;
          end
        end
      end
      ST_CHECK: begin
        state_next = stat.late ? ST_MISS : ST_EDIT;
      end
      ST_EDIT: begin
        if (stat.edit_end) begin
          state_next = ST_MISS;
        end else begin
          op         = OP_EDIT_RD;
          state_next = ST_TRK;
        end
      end
      ST_TRK: begin
        // Missing track: skip it
        if (stat.trk_end) begin
          op         = OP_NEXT_TRACK;
          state_next = ST_EDIT;
        end else begin
          op         = OP_TRK_RD;
          state_next = ST_TRK_CMP;
        end
      end
      ST_TRK_CMP: begin
        if (stat.trk_match) begin
          if (stat.len_zero) begin
            op         = OP_NEXT_TRACK;
            state_next = ST_EDIT;
          end else begin
            op         = OP_TRK_TAKE;
            state_next = ST_KL;
          end
        end else begin
          op         = OP_TRK_NEXT;
          state_next = ST_TRK;
        end
      end
      ST_KL: begin
        if (stat.kl_end) begin
          op         = OP_PAIR_START;
          state_next = ST_PAIR;
        end else begin
          op         = OP_KL_RD;
          state_next = ST_KEY;
        end
      end
      ST_KEY: begin
        // Unresolved key ends the walk
        if (stat.key_end) begin
          state_next = ST_MISS;
        end else begin
          op         = OP_KEY_RD;
          state_next = ST_KEY_CMP;
        end
      end
      ST_KEY_CMP: begin
        if (stat.key_match) begin
          op         = OP_KEY_TAKE;
          state_next = ST_KL;
        end else begin
          op         = OP_KEY_NEXT;
          state_next = ST_KEY;
        end
      end
      ST_PAIR: begin
        op         = OP_PAIR_RD;
        state_next = ST_PAIR_CMP;
      end
      ST_PAIR_CMP: begin
        if (stat.pair_hit) begin
          op         = OP_PAIR_HIT;
          state_next = ST_CAM;
        end else if (stat.pair_last) begin
          op         = OP_PAIR_LAST;
          state_next = ST_EDIT;
        end else begin
          op         = OP_PAIR_NEXT;
          state_next = ST_PAIR;
        end
      end
      ST_CAM: begin
        if (stat.cam_end) begin
          if (stat.cam_found) begin
            op         = OP_FLD_START;
            state_next = ST_FLD;
          end else begin
            state_next = ST_MISS;
          end
        end else begin
          op         = OP_CAM_RD;
          state_next = ST_CAM_CMP;
        end
      end
      ST_CAM_CMP: begin
        op         = OP_CAM_STEP;
        state_next = ST_CAM;
      end
      ST_FLD: begin
        op         = OP_FLD_RD0;
        state_next = ST_FLD_A;
      end
      ST_FLD_A: begin
        op         = OP_FLD_RD1;
        state_next = ST_FLD_B;
      end
      ST_FLD_B: begin
        op         = OP_BLEND_GO;
        state_next = ST_BLEND;
      end
      ST_BLEND: begin
        if (stat.blend_done) begin
          op         = OP_FLD_STORE;
          state_next = stat.fld_last ? ST_HIT : ST_FLD;
        end
      end
      ST_HIT: begin
        if (stat.out_free) begin
          op         = OP_OUT_HIT;
          state_next = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (stat.out_free) begin
          op         = OP_OUT_MISS;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/keyframe_camera_sampler.sv
// Top level of the keyframe camera sampler: controller, datapath and their hookup.
// Depends on kcs_pkg, kcs_ctrl, kcs_dp and kcs_blend.
//
// Load beats (camera field, key, track header, track key id, editing track) are taken
// in the idle state and give no result. A sample beat gives exactly one result beat and
// takes one item at a time. Its run time grows with each editing entry visited, each
// track id compared, each key id compared while resolving each key of a visited track,
// each key tested in the pair scan, each key resolved and each camera entry scanned, and
// with the fields. The field cost comes from the shared interpolation unit, which forms
// one quotient digit a cycle; the search costs come from the single read port of each
// table, each entry read and compared in turn. A rejected or unmatched sample ends as
// soon as the walk decides it. A new beat is accepted while the previous result waits.
module keyframe_camera_sampler #(
  parameter int MAX_CAMERAS        = kcs_pkg::DEF_MAX_CAMERAS,
  parameter int MAX_KEYS           = kcs_pkg::DEF_MAX_KEYS,
  parameter int MAX_TRACKS         = kcs_pkg::DEF_MAX_TRACKS,
  parameter int MAX_KEYS_PER_TRACK = kcs_pkg::DEF_MAX_KEYS_PER_TRACK,
  parameter int MAX_EDIT_TRACKS    = kcs_pkg::DEF_MAX_EDIT_TRACKS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [kcs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     req_type,
  input  logic [7:0]                     slot,
  input  logic [5:0]                     position,
  input  logic [2:0]                     field_sel,
  input  logic [31:0]                    id_a,
  input  logic [31:0]                    id_b,
  input  logic signed [31:0]             value,
  input  logic [31:0]                    sample_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           found,
  output logic signed [31:0]             eye_x,
  output logic signed [31:0]             eye_y,
  output logic signed [31:0]             eye_z,
  output logic signed [31:0]             look_x,
  output logic signed [31:0]             look_y,
  output logic signed [31:0]             look_z,
  output logic signed [31:0]             roll_out,
  output logic signed [31:0]             fov_out,
  output logic [3:0]                     track_pos,
  output logic [31:0]                    camera_id_out
);
  import kcs_pkg::*;

  kcs_op_t   op;
  kcs_stat_t stat;

  kcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .stat     (stat),
    .op       (op),
    .in_ready (in_ready)
  );

  kcs_dp #(
    .MAX_CAMERAS        (MAX_CAMERAS),
    .MAX_KEYS           (MAX_KEYS),
    .MAX_TRACKS         (MAX_TRACKS),
    .MAX_KEYS_PER_TRACK (MAX_KEYS_PER_TRACK),
    .MAX_EDIT_TRACKS    (MAX_EDIT_TRACKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .slot          (slot),
    .position      (position),
    .field_sel     (field_sel),
    .id_a          (id_a),
    .id_b          (id_b),
    .value         (value),
    .sample_time   (sample_time),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .found         (found),
    .eye_x         (eye_x),
    .eye_y         (eye_y),
    .eye_z         (eye_z),
    .look_x        (look_x),
    .look_y        (look_y),
    .look_z        (look_z),
    .roll_out      (roll_out),
    .fov_out       (fov_out),
    .track_pos     (track_pos),
    .camera_id_out (camera_id_out)
  );

endmodule
